// ===== rtl/mls_pkg.sv =====
// Motor link supervisor package: mode, action and command codes, drive state
// codes, flag bit positions and the transaction structs.
// No dependencies.
package mls_pkg;

  typedef enum logic [3:0] {
    MODE_UNKNOWN   = 4'd0,
    MODE_IDLE_NA   = 4'd1,
    MODE_ALIGN_TX  = 4'd2,
    MODE_ALIGNING  = 4'd3,
    MODE_IDLE_AL   = 4'd4,
    MODE_TORQUE_TX = 4'd5,
    MODE_START_TX  = 4'd6,
    MODE_RUNNING   = 4'd7,
    MODE_STOP_TX   = 4'd8,
    MODE_STOPPING  = 4'd9,
    MODE_FAULT_ACT = 4'd10,
    MODE_FAULT_PAS = 4'd11,
    MODE_ACK_TX    = 4'd12
  } mode_t;

  typedef enum logic [1:0] {
    ACT_USER      = 2'd0,
    ACT_TELEMETRY = 2'd1,
    ACT_RESPONSE  = 2'd2,
    ACT_TIMEOUT   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    UCMD_ALIGN     = 2'd0,
    UCMD_START     = 2'd1,
    UCMD_STOP      = 2'd2,
    UCMD_ACK_FAULT = 2'd3
  } ucmd_t;

  typedef enum logic [2:0] {
    CMD_NONE         = 3'd0,
    CMD_ALIGN        = 3'd1,
    CMD_RESET_TORQUE = 3'd2,
    CMD_START        = 3'd3,
    CMD_STOP         = 3'd4,
    CMD_ACK_FAULT    = 3'd5
  } cmd_t;

  localparam logic [4:0] DS_IDLE        = 5'd0;
  localparam logic [4:0] DS_ALIGN_FIRST = 5'd1;
  localparam logic [4:0] DS_ALIGN_LAST  = 5'd4;
  localparam logic [4:0] DS_START_FIRST = 5'd5;
  localparam logic [4:0] DS_START_LAST  = 5'd10;
  localparam logic [4:0] DS_RUN         = 5'd11;
  localparam logic [4:0] DS_STOP_FIRST  = 5'd12;
  localparam logic [4:0] DS_STOP_LAST   = 5'd14;
  localparam logic [4:0] DS_FAULT_NOW   = 5'd15;
  localparam logic [4:0] DS_FAULT_OVER  = 5'd16;
  localparam logic [4:0] DS_ICL_WAIT    = 5'd17;

  localparam int FLAG_ALIVE   = 0;
  localparam int FLAG_READY   = 1;
  localparam int FLAG_ALIGNED = 2;
  localparam int FLAG_STARTED = 3;
  localparam int FLAG_FAULT   = 4;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] host_request;
    logic [4:0] drive_state;
    logic       response_nack;
  } in_item_t;

  typedef struct packed {
    logic [3:0] supervisor_state;
    logic [4:0] event_flags;
    logic [2:0] send_command;
    logic [7:0] command_target;
    logic       command_rejected;
    logic       state_changed;
  } out_item_t;

endpackage

// ===== rtl/motor_link_supervisor_fsm.sv =====
// Motor link supervisor: input register, supervisor state machine, result register.
// A transaction waits in the input register; its result is loaded into the result register when it advances.
// Throughput: one transaction per cycle while the result is not stalled; the mode/flag update is a registered loop.
// in_ready drops only when the input register is full and the result is stalled.
// Reset (rst, synchronous): mode unknown, all flags clear, drive address 0, pipeline empty.
// Depends on mls_pkg and mls_core.
module motor_link_supervisor_fsm (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mls_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output mls_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  logic               valid1;
  mls_pkg::in_item_t  item1;
  logic [7:0]         drive_addr;
  logic               advance;
  mls_pkg::out_item_t result;

  assign advance  = valid1 && (!out_valid || out_ready);
  assign in_ready = !valid1 || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_addr <= '0;
    end else if (cfg_wr_en) begin
      drive_addr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid1    <= (in_valid && in_ready) || (valid1 && !advance);
      out_valid <= advance || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item1 <= in_item;
    end
    if (advance) begin
      out_item <= result;
    end
  end

  mls_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (item1),
    .drive_addr (drive_addr),
    .result     (result)
  );

`ifndef NO_ASSERTIONS
  a_target_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.send_command == mls_pkg::CMD_NONE |-> out_item.command_target == 8'd0)
    else $error("command_target set without a command");

  a_unknown_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.supervisor_state == mls_pkg::MODE_UNKNOWN |->
      out_item.event_flags == 5'd0)
    else $error("flags set in unknown mode");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.command_rejected |->
      !out_item.state_changed && out_item.send_command == mls_pkg::CMD_NONE)
    else $error("rejected command moved the state");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> valid1 && out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed transaction not presented");
`endif

endmodule

// ===== rtl/mls_core.sv =====
// Supervisor state machine: mode and flag registers plus the event decode
// that forms the next mode, flags and link command for one transaction.
// Depends on mls_pkg.
module mls_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  mls_pkg::in_item_t item,
  input  logic [7:0]        drive_addr,
  output mls_pkg::out_item_t result
);

  mls_pkg::mode_t mode;
  mls_pkg::mode_t mode_next;
  logic [4:0]     flags;
  logic [4:0]     flags_next;

  mls_pkg::mode_t target;
  logic           target_vld;
  logic           rejected;
  logic           move;
  mls_pkg::cmd_t  cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= mls_pkg::MODE_UNKNOWN;
      flags <= '0;
    end else if (step) begin
      mode  <= mode_next;
      flags <= flags_next;
    end
  end

  // Pick the requested target mode for this event, if any.
  always_comb begin
    target     = mode;
    target_vld = 1'b0;
    rejected   = 1'b0;
    unique case (mls_pkg::action_t'(item.action))
      mls_pkg::ACT_USER: begin
        // Only the four idle/running/fault-waiting modes take user commands.
        case (mode)
          mls_pkg::MODE_IDLE_NA: begin
            target     = mls_pkg::MODE_ALIGN_TX;
            target_vld = (item.host_request == mls_pkg::UCMD_ALIGN);
            rejected   = !target_vld;
          end
          mls_pkg::MODE_IDLE_AL: begin
            target     = mls_pkg::MODE_TORQUE_TX;
            target_vld = (item.host_request == mls_pkg::UCMD_START);
            rejected   = !target_vld;
          end
          mls_pkg::MODE_RUNNING: begin
            target     = mls_pkg::MODE_STOP_TX;
            target_vld = (item.host_request == mls_pkg::UCMD_STOP);
            rejected   = !target_vld;
          end
          mls_pkg::MODE_FAULT_PAS: begin
            target     = mls_pkg::MODE_ACK_TX;
            target_vld = (item.host_request == mls_pkg::UCMD_ACK_FAULT);
            rejected   = !target_vld;
          end
          default: ;
        endcase
      end
      mls_pkg::ACT_TELEMETRY: begin
        case (item.drive_state) inside
          [mls_pkg::DS_STOP_FIRST:mls_pkg::DS_STOP_LAST], mls_pkg::DS_ICL_WAIT: begin
            target     = mls_pkg::MODE_STOPPING;
            target_vld = 1'b1;
          end
          mls_pkg::DS_FAULT_NOW: begin
            target     = mls_pkg::MODE_FAULT_ACT;
            target_vld = 1'b1;
          end
          mls_pkg::DS_FAULT_OVER: begin
            // ignored while the fault acknowledge is outstanding
            target     = mls_pkg::MODE_FAULT_PAS;
            target_vld = (mode != mls_pkg::MODE_ACK_TX);
          end
          [mls_pkg::DS_START_FIRST:mls_pkg::DS_START_LAST]: begin
            target     = mls_pkg::MODE_START_TX;
            target_vld = 1'b1;
          end
          [mls_pkg::DS_ALIGN_FIRST:mls_pkg::DS_ALIGN_LAST]: begin
            target     = mls_pkg::MODE_ALIGNING;
            target_vld = 1'b1;
          end
          default: begin
            // per-mode handler: only idle and run reports matter here
            case (mode)
              mls_pkg::MODE_UNKNOWN: begin
                target     = mls_pkg::MODE_IDLE_NA;
                target_vld = (item.drive_state == mls_pkg::DS_IDLE);
              end
              mls_pkg::MODE_ALIGNING, mls_pkg::MODE_STOP_TX,
              mls_pkg::MODE_ACK_TX, mls_pkg::MODE_STOPPING: begin
                target     = mls_pkg::MODE_IDLE_AL;
                target_vld = (item.drive_state == mls_pkg::DS_IDLE);
              end
              mls_pkg::MODE_START_TX: begin
                target     = mls_pkg::MODE_RUNNING;
                target_vld = (item.drive_state == mls_pkg::DS_RUN);
              end
              default: ;
            endcase
          end
        endcase
      end
      mls_pkg::ACT_RESPONSE: begin
        if (item.response_nack) begin
          target     = mls_pkg::MODE_UNKNOWN;
          target_vld = 1'b1;
        end else if (mode == mls_pkg::MODE_ALIGN_TX) begin
          target     = mls_pkg::MODE_ALIGNING;
          target_vld = 1'b1;
        end else if (mode == mls_pkg::MODE_TORQUE_TX) begin
          target     = mls_pkg::MODE_START_TX;
          target_vld = 1'b1;
        end
      end
      mls_pkg::ACT_TIMEOUT: begin
        target     = mls_pkg::MODE_UNKNOWN;
        target_vld = 1'b1;
      end
      default: ;
    endcase
  end

  // Exit action of the old mode, then entry action of the new one.
  always_comb begin
    move       = target_vld && (target != mode);
    mode_next  = move ? target : mode;
    flags_next = flags;
    cmd        = mls_pkg::CMD_NONE;
    if (move) begin
      case (mode)
        mls_pkg::MODE_UNKNOWN: flags_next[mls_pkg::FLAG_ALIVE]   = 1'b1;
        mls_pkg::MODE_IDLE_AL: flags_next[mls_pkg::FLAG_READY]   = 1'b0;
        mls_pkg::MODE_RUNNING: flags_next[mls_pkg::FLAG_STARTED] = 1'b0;
        default: ;
      endcase
      case (target)
        mls_pkg::MODE_UNKNOWN:   flags_next = '0;
        mls_pkg::MODE_ALIGN_TX:  cmd = mls_pkg::CMD_ALIGN;
        mls_pkg::MODE_IDLE_AL: begin
          flags_next[mls_pkg::FLAG_READY]   = 1'b1;
          flags_next[mls_pkg::FLAG_ALIGNED] = 1'b1;
        end
        mls_pkg::MODE_TORQUE_TX: cmd = mls_pkg::CMD_RESET_TORQUE;
        mls_pkg::MODE_START_TX:  cmd = mls_pkg::CMD_START;
        mls_pkg::MODE_RUNNING:   flags_next[mls_pkg::FLAG_STARTED] = 1'b1;
        mls_pkg::MODE_STOP_TX:   cmd = mls_pkg::CMD_STOP;
        mls_pkg::MODE_FAULT_ACT, mls_pkg::MODE_FAULT_PAS:
          flags_next[mls_pkg::FLAG_FAULT] = 1'b1;
        mls_pkg::MODE_ACK_TX:    cmd = mls_pkg::CMD_ACK_FAULT;
        default: ;
      endcase
    end
  end

  always_comb begin
    result.supervisor_state = mode_next;
    result.event_flags      = flags_next;
    result.send_command     = cmd;
    result.command_target   = (cmd != mls_pkg::CMD_NONE) ? drive_addr : 8'd0;
    result.command_rejected = rejected;
    result.state_changed    = move;
  end

endmodule
